/* src/rrp_pkg.sv */
// Shared types and constants for the rectangle raster painter.
// Used by the top level and by the port checker; depends on nothing.
`default_nettype none

package rrp_pkg;

    // Width of a canvas dimension: the 10-bit size registers and sizes up to 1024.
    localparam int DIM_W   = 11;
    localparam int FIELD_W = 20;
    localparam int CHAR_W  = 8;

    // Configuration port.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam int SIZE_W  = 10;

    localparam logic [1:0] REG_CANVAS_WIDTH  = 2'd0;
    localparam logic [1:0] REG_CANVAS_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BACKGROUND    = 2'd2;

    localparam logic [SIZE_W-1:0] RST_CANVAS_WIDTH  = 10'd512;
    localparam logic [SIZE_W-1:0] RST_CANVAS_HEIGHT = 10'd512;
    localparam logic [CHAR_W-1:0] RST_BACKGROUND    = 8'd32;

    // Command codes.
    localparam logic [1:0] OP_DRAW  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_REJECT  = 2'd1;
    localparam logic [1:0] ST_OUTSIDE = 2'd2;

    // Fill type characters: 'R' filled, 'r' outline only.
    localparam logic [CHAR_W-1:0] TYPE_FULL    = 8'h52;
    localparam logic [CHAR_W-1:0] TYPE_OUTLINE = 8'h72;

endpackage

`default_nettype wire

/* src/rrp_canvas.sv */
// Canvas byte memory: one synchronous write port and one read port with
// registered read data. No package dependencies.
`default_nettype none

module rrp_canvas #(
    parameter int ADDR_W = 18,
    parameter int DEPTH  = 262144
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [7:0]        wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [7:0]        rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* src/rectangle_raster_painter.sv */
// Top level of the rectangle raster painter: command sequencer, register port
// and pixel classifier. Depends on rrp_pkg and instantiates rrp_canvas.
//
// The block holds a byte canvas of MAX_COLS by MAX_ROWS pixels in one
// synchronous memory. A command word is taken when start is high and busy is
// low; every command gives exactly one result word, shown on status and
// pixel_value for a single cycle while done is high. The receiver cannot hold
// a result off, so it must sample done every cycle. A read inside the canvas
// issues the memory read at the accepting edge and registers the byte in the
// read state; a read outside the canvas, a rejected draw, a draw on an empty
// canvas and the unused opcode set done at the accepting edge itself; a draw
// sweeps cols*rows pixels, where cols and rows are the in-use canvas size; a
// clear sweeps MAX_COLS*MAX_ROWS pixels. Draw and clear are bound by the
// single write port of the canvas memory, which takes one pixel per cycle as
// the sweep walks the canvas row by row. busy stays high for the whole sweep
// or read. The canvas contents are undefined after reset, so a clear must
// come before any pixel is read. Configuration (canvas_width at byte address 0,
// canvas_height at 4, background_char at 8) should be written only while the
// block is idle; sizes above MAX_COLS or MAX_ROWS act as the maximum.
`default_nettype none

module rectangle_raster_painter
    import rrp_pkg::*;
#(
    parameter int MAX_COLS  = 512,
    parameter int MAX_ROWS  = 512,
    parameter int FRAC_BITS = 8
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // Configuration port
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [PADDR_W-1:0]        paddr,
    input  wire logic [PDATA_W-1:0]        pwdata,
    output logic      [PDATA_W-1:0]        prdata,
    output logic                           pready,
    // Command channel
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [1:0]                opcode,
    input  wire logic signed [FIELD_W-1:0] rect_left,
    input  wire logic signed [FIELD_W-1:0] rect_top,
    input  wire logic signed [FIELD_W-1:0] rect_width,
    input  wire logic signed [FIELD_W-1:0] rect_height,
    input  wire logic [CHAR_W-1:0]         fill_type,
    input  wire logic [CHAR_W-1:0]         paint_char,
    input  wire logic [8:0]                pixel_col,
    input  wire logic [8:0]                pixel_row,
    // Result channel
    output logic                           done,
    output logic [1:0]                     status,
    output logic [CHAR_W-1:0]              pixel_value
);

    // Column and row index widths; the memory row stride is a power of two so
    // that the address is a plain concatenation of row and column.
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ADDR_W = COL_W + ROW_W;
    localparam int DEPTH  = MAX_ROWS * (1 << COL_W);

    // Coordinate width: wide enough for a shifted pixel index and for the
    // rectangle edge sums at full precision, plus a sign bit.
    localparam int CW = FRAC_BITS + 24;
    localparam logic signed [CW-1:0] ONE = CW'(1) << FRAC_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_READ
    } state_t;

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [SIZE_W-1:0] canvas_width_reg;
    logic [SIZE_W-1:0] canvas_height_reg;
    logic [CHAR_W-1:0] background_reg;
    logic              cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_width_reg  <= RST_CANVAS_WIDTH;
            canvas_height_reg <= RST_CANVAS_HEIGHT;
            background_reg    <= RST_BACKGROUND;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_CANVAS_WIDTH:  canvas_width_reg  <= pwdata[SIZE_W-1:0];
                REG_CANVAS_HEIGHT: canvas_height_reg <= pwdata[SIZE_W-1:0];
                REG_BACKGROUND:    background_reg    <= pwdata[CHAR_W-1:0];
                default:
                begin
                    // Addresses beyond the register list are ignored.
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_CANVAS_WIDTH:  prdata = PDATA_W'(canvas_width_reg);
            REG_CANVAS_HEIGHT: prdata = PDATA_W'(canvas_height_reg);
            REG_BACKGROUND:    prdata = PDATA_W'(background_reg);
            default:           prdata = '0;
        endcase
    end

    // In-use canvas size: the size registers clipped to the memory dimensions.
    logic [DIM_W-1:0] used_cols;
    logic [DIM_W-1:0] used_rows;

    assign used_cols = (DIM_W'(canvas_width_reg) > DIM_W'(MAX_COLS)) ?
                       DIM_W'(MAX_COLS) : DIM_W'(canvas_width_reg);
    assign used_rows = (DIM_W'(canvas_height_reg) > DIM_W'(MAX_ROWS)) ?
                       DIM_W'(MAX_ROWS) : DIM_W'(canvas_height_reg);

    // ---------------------------------------------------------------------
    // Command decode at the accepting edge
    // ---------------------------------------------------------------------
    logic accept;
    logic draw_reject;
    logic canvas_empty;
    logic read_outside;

    assign accept       = start && !busy;
    assign draw_reject  = rect_width[FIELD_W-1] || rect_height[FIELD_W-1] ||
                          ((fill_type != TYPE_FULL) && (fill_type != TYPE_OUTLINE));
    assign canvas_empty = (used_cols == '0) || (used_rows == '0);
    assign read_outside = (DIM_W'(pixel_col) >= used_cols) ||
                          (DIM_W'(pixel_row) >= used_rows);

    // Rectangle bounds, kept for the length of a draw sweep. The border band
    // is the strip less than one unit inside each edge.
    logic signed [CW-1:0] left_reg;
    logic signed [CW-1:0] left_in_reg;
    logic signed [CW-1:0] right_in_reg;
    logic signed [CW-1:0] right_reg;
    logic signed [CW-1:0] top_reg;
    logic signed [CW-1:0] top_in_reg;
    logic signed [CW-1:0] bottom_in_reg;
    logic signed [CW-1:0] bottom_reg;
    logic                 full_reg;
    logic [CHAR_W-1:0]    paint_reg;

    logic signed [CW-1:0] left_ext;
    logic signed [CW-1:0] top_ext;
    logic signed [CW-1:0] right_sum;
    logic signed [CW-1:0] bottom_sum;

    assign left_ext   = CW'(rect_left);
    assign top_ext    = CW'(rect_top);
    assign right_sum  = left_ext + CW'(rect_width);
    assign bottom_sum = top_ext + CW'(rect_height);

    always_ff @(posedge clk)
    begin
        if (accept && (opcode == OP_DRAW))
        begin
            left_reg      <= left_ext;
            left_in_reg   <= left_ext + ONE;
            right_in_reg  <= right_sum - ONE;
            right_reg     <= right_sum;
            top_reg       <= top_ext;
            top_in_reg    <= top_ext + ONE;
            bottom_in_reg <= bottom_sum - ONE;
            bottom_reg    <= bottom_sum;
            full_reg      <= (fill_type == TYPE_FULL);
            paint_reg     <= paint_char;
        end
    end

    // ---------------------------------------------------------------------
    // Sequencer: runs every command; sweeps the canvas for draw and clear, one pixel a cycle
    // ---------------------------------------------------------------------
    state_t            state_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [1:0]        status_reg;
    logic [CHAR_W-1:0] pixel_value_reg;
    logic [COL_W-1:0]  x_reg;
    logic [ROW_W-1:0]  y_reg;
    logic [COL_W-1:0]  x_last_reg;
    logic [ROW_W-1:0]  y_last_reg;
    logic              clear_mode_reg;
    logic [7:0]        canvas_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            busy_reg        <= 1'b0;
            done_reg        <= 1'b0;
            status_reg      <= ST_OK;
            pixel_value_reg <= '0;
            x_reg           <= '0;
            y_reg           <= '0;
            x_last_reg      <= '0;
            y_last_reg      <= '0;
            clear_mode_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        status_reg      <= ST_OK;
                        pixel_value_reg <= '0;
                        x_reg           <= '0;
                        y_reg           <= '0;
                        unique case (opcode)
                            OP_DRAW:
                            begin
                                if (draw_reject)
                                begin
                                    status_reg <= ST_REJECT;
                                    done_reg   <= 1'b1;
                                end
                                else if (canvas_empty)
                                begin
                                    done_reg <= 1'b1;
                                end
                                else
                                begin
                                    x_last_reg     <= COL_W'(used_cols - DIM_W'(1));
                                    y_last_reg     <= ROW_W'(used_rows - DIM_W'(1));
                                    clear_mode_reg <= 1'b0;
                                    busy_reg       <= 1'b1;
                                    state_reg      <= S_SWEEP;
                                end
                            end
                            OP_READ:
                            begin
                                if (read_outside)
                                begin
                                    status_reg <= ST_OUTSIDE;
                                    done_reg   <= 1'b1;
                                end
                                else
                                begin
                                    // The memory read is issued at this edge.
                                    busy_reg  <= 1'b1;
                                    state_reg <= S_READ;
                                end
                            end
                            OP_CLEAR:
                            begin
                                // Clear covers the whole memory, not only the
                                // in-use area.
                                x_last_reg     <= COL_W'(MAX_COLS - 1);
                                y_last_reg     <= ROW_W'(MAX_ROWS - 1);
                                clear_mode_reg <= 1'b1;
                                busy_reg       <= 1'b1;
                                state_reg      <= S_SWEEP;
                            end
                            OP_NOP:
                            begin
                                done_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_SWEEP:
                begin
                    if (x_reg == x_last_reg)
                    begin
                        x_reg <= '0;
                        if (y_reg == y_last_reg)
                        begin
                            busy_reg  <= 1'b0;
                            done_reg  <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            y_reg <= y_reg + ROW_W'(1);
                        end
                    end
                    else
                    begin
                        x_reg <= x_reg + COL_W'(1);
                    end
                end
                S_READ:
                begin
                    pixel_value_reg <= canvas_rdata;
                    busy_reg        <= 1'b0;
                    done_reg        <= 1'b1;
                    state_reg       <= S_IDLE;
                end
                default:
                begin
                    busy_reg  <= 1'b0;
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = busy_reg;
    assign done        = done_reg;
    assign status      = status_reg;
    assign pixel_value = pixel_value_reg;

    // ---------------------------------------------------------------------
    // Pixel classifier for the sweep position. Pixel (x, y) sits at the
    // point (x, y) scaled by one unit; it is painted when it lies in the
    // closed rectangle and is either in the border band or the fill is full.
    // ---------------------------------------------------------------------
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic                 inside_rect;
    logic                 on_border;
    logic                 paint_pixel;

    assign px = CW'(x_reg) << FRAC_BITS;
    assign py = CW'(y_reg) << FRAC_BITS;

    assign inside_rect = (px >= left_reg) && (px <= right_reg) &&
                         (py >= top_reg) && (py <= bottom_reg);
    assign on_border   = (px < left_in_reg) || (px > right_in_reg) ||
                         (py < top_in_reg) || (py > bottom_in_reg);
    assign paint_pixel = inside_rect && (on_border || full_reg);

    // ---------------------------------------------------------------------
    // Canvas memory. Read data is used only by a read command, which never runs
    // during a sweep, so a read and a write never meet on the same entry.
    // ---------------------------------------------------------------------
    logic              canvas_we;
    logic [ADDR_W-1:0] canvas_waddr;
    logic [7:0]        canvas_wdata;
    logic [ADDR_W-1:0] canvas_raddr;

    assign canvas_we    = (state_reg == S_SWEEP) && (clear_mode_reg || paint_pixel);
    assign canvas_waddr = {y_reg, x_reg};
    assign canvas_wdata = clear_mode_reg ? background_reg : paint_reg;
    assign canvas_raddr = {ROW_W'(pixel_row), COL_W'(pixel_col)};

    rrp_canvas #(
        .ADDR_W (ADDR_W),
        .DEPTH  (DEPTH)
    ) u_canvas (
        .clk   (clk),
        .we    (canvas_we),
        .waddr (canvas_waddr),
        .wdata (canvas_wdata),
        .raddr (canvas_raddr),
        .rdata (canvas_rdata)
    );

endmodule

`default_nettype wire

/* src/rrp_checker.sv */
// Port-level checker for the rectangle raster painter, bound to the top level.
// Depends on rrp_pkg for the command and status codes.
`default_nettype none

module rrp_checker
    import rrp_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic [1:0]        opcode,
    input wire logic [CHAR_W-1:0] fill_type,
    input wire logic              done,
    input wire logic [1:0]        status,
    input wire logic [CHAR_W-1:0] pixel_value
);

    // A result word never appears while a command is still in progress.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word shown while busy");

    // Every result word follows an accepted command or the end of a busy period.
    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) || ($past(start) && !$past(busy))))
        else $error("result word without a command");

    // Error results carry no pixel byte, and the unused status code never appears.
    a_error_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_OK)) |-> ((pixel_value == '0) && (status != 2'd3)))
        else $error("bad status or pixel byte on an error result");

    // A draw with an unknown fill type is rejected in the very next cycle.
    a_bad_type_rejected: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (opcode == OP_DRAW) &&
         (fill_type != TYPE_FULL) && (fill_type != TYPE_OUTLINE))
        |=> (done && (status == ST_REJECT) && !busy))
        else $error("draw with unknown fill type was not rejected");

    // The unused opcode answers at once with an ok status.
    a_nop_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (opcode == OP_NOP)) |=> (done && (status == ST_OK)))
        else $error("unused opcode did not answer in one cycle");

endmodule

bind rectangle_raster_painter rrp_checker u_rrp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .opcode      (opcode),
    .fill_type   (fill_type),
    .done        (done),
    .status      (status),
    .pixel_value (pixel_value)
);

`default_nettype wire

/* tb/rectangle_raster_painter_tb.sv */
// Self-checking testbench for the rectangle raster painter: a directed table of
// register writes and command words followed by random words, checked against an in-bench canvas or typed-in results.
// Depends on rrp_pkg and rectangle_raster_painter; reads no files.
`timescale 1ns / 1ps

module rectangle_raster_painter_tb;
    import rrp_pkg::*;

    localparam int MAX_COLS  = 512;
    localparam int MAX_ROWS  = 512;
    localparam int FRAC_BITS = 8;

    // One canvas unit in fixed point, and the same as a 64-bit value for the
    // edge arithmetic.
    localparam int     UNIT       = 1 << FRAC_BITS;
    localparam longint PIXEL_ONE  = longint'(1) << FRAC_BITS;
    localparam int     FIELD_MAX  = (1 << (FIELD_W - 1)) - 1;
    localparam int     FIELD_MIN  = -(1 << (FIELD_W - 1));

    // Register index past the end of the map; writes to it must be ignored.
    localparam logic [1:0] REG_UNMAPPED = 2'd3;

    // A clear sweeps the whole store, so the slowest correct run is dominated by
    // two clears and one full-canvas draw. The limit leaves a wide margin.
    localparam int CYCLE_LIMIT     = 4_000_000;
    localparam int RANDOM_PHASES   = 4;
    localparam int WORDS_PER_PHASE = 18;
    localparam int RANDOM_WORDS    = RANDOM_PHASES * WORDS_PER_PHASE;

    typedef struct {
        logic [1:0]                op;
        logic signed [FIELD_W-1:0] left;
        logic signed [FIELD_W-1:0] top;
        logic signed [FIELD_W-1:0] wid;
        logic signed [FIELD_W-1:0] hgt;
        logic [CHAR_W-1:0]         ftype;
        logic [CHAR_W-1:0]         paint;
        logic [8:0]                col;
        logic [8:0]                row;
    } paint_cmd_t;

    typedef struct {
        logic [1:0]        status;
        logic [CHAR_W-1:0] pixel;
    } canvas_word_t;

    // A row of the directed table is either a register write or a command word.
    // Command rows carry a typed-in result only where it is obvious by
    // inspection; the rest are checked against the canvas predictor.
    typedef struct {
        bit           is_cfg;
        logic [1:0]   reg_idx;
        logic [31:0]  reg_val;
        paint_cmd_t   cmd;
        bit           typed;
        canvas_word_t want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    logic                      start = 1'b0;
    logic                      busy;
    logic [1:0]                opcode = OP_NOP;
    logic signed [FIELD_W-1:0] rect_left = '0;
    logic signed [FIELD_W-1:0] rect_top = '0;
    logic signed [FIELD_W-1:0] rect_width = '0;
    logic signed [FIELD_W-1:0] rect_height = '0;
    logic [CHAR_W-1:0]         fill_type = '0;
    logic [CHAR_W-1:0]         paint_char = '0;
    logic [8:0]                pixel_col = '0;
    logic [8:0]                pixel_row = '0;

    logic              done;
    logic [1:0]        status;
    logic [CHAR_W-1:0] pixel_value;

    // Shadow of the block: its registers and the whole byte canvas.
    logic [SIZE_W-1:0] shadow_width = RST_CANVAS_WIDTH;
    logic [SIZE_W-1:0] shadow_height = RST_CANVAS_HEIGHT;
    logic [CHAR_W-1:0] shadow_bg = RST_BACKGROUND;
    bit [CHAR_W-1:0]   canvas_image [MAX_COLS*MAX_ROWS];

    canvas_word_t predicted_words[$];
    stim_row_t    directed_rows[$];
    int           mismatch_count = 0;
    int unsigned  cycle_count = 0;

    rectangle_raster_painter #(
        .MAX_COLS  (MAX_COLS),
        .MAX_ROWS  (MAX_ROWS),
        .FRAC_BITS (FRAC_BITS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .rect_left   (rect_left),
        .rect_top    (rect_top),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .fill_type   (fill_type),
        .paint_char  (paint_char),
        .pixel_col   (pixel_col),
        .pixel_row   (pixel_row),
        .done        (done),
        .status      (status),
        .pixel_value (pixel_value)
    );

    always #2 clk = ~clk;

    // Size registers above the canvas maximum behave as the maximum.
    function automatic int used_cols();
        return (int'(shadow_width) > MAX_COLS) ? MAX_COLS : int'(shadow_width);
    endfunction

    function automatic int used_rows();
        return (int'(shadow_height) > MAX_ROWS) ? MAX_ROWS : int'(shadow_height);
    endfunction

    // Applies one command word to the shadow canvas and works out the word the
    // block must answer with. A draw tests every in-use pixel against the closed
    // rectangle; pixels within one unit of any edge are border pixels.
    task automatic canvas_predict(input paint_cmd_t c, output canvas_word_t res);
        longint l;
        longint t;
        longint rgt;
        longint bot;
        longint px;
        longint py;
        int     cols;
        int     rows;
        bit     on_border;
        res.status = ST_OK;
        res.pixel  = '0;
        cols = used_cols();
        rows = used_rows();
        case (c.op)
            OP_DRAW:
            begin
                l   = c.left;
                t   = c.top;
                rgt = l + longint'(c.wid);
                bot = t + longint'(c.hgt);
                if (c.wid < 0 || c.hgt < 0
                        || (c.ftype != TYPE_FULL && c.ftype != TYPE_OUTLINE))
                begin
                    res.status = ST_REJECT;
                end
                else
                begin
                    for (int y = 0; y < rows; y++)
                    begin
                        py = longint'(y) * PIXEL_ONE;
                        if (py < t || py > bot)
                            continue;
                        for (int x = 0; x < cols; x++)
                        begin
                            px = longint'(x) * PIXEL_ONE;
                            if (px < l || px > rgt)
                                continue;
                            on_border = (px - l < PIXEL_ONE) || (rgt - px < PIXEL_ONE)
                                     || (py - t < PIXEL_ONE) || (bot - py < PIXEL_ONE);
                            if (on_border || c.ftype == TYPE_FULL)
                                canvas_image[y*MAX_COLS + x] = c.paint;
                        end
                    end
                end
            end
            OP_READ:
            begin
                if (int'(c.col) >= cols || int'(c.row) >= rows)
                    res.status = ST_OUTSIDE;
                else
                    res.pixel = canvas_image[int'(c.row)*MAX_COLS + int'(c.col)];
            end
            OP_CLEAR:
            begin
                // The clear covers the whole store, not only the in-use area.
                foreach (canvas_image[i])
                    canvas_image[i] = shadow_bg;
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic paint_cmd_t mk_cmd(logic [1:0] op, int l, int t, int w, int h,
                                          int ft, int pc, int col, int row);
        paint_cmd_t c;
        c.op    = op;
        c.left  = FIELD_W'(l);
        c.top   = FIELD_W'(t);
        c.wid   = FIELD_W'(w);
        c.hgt   = FIELD_W'(h);
        c.ftype = CHAR_W'(ft);
        c.paint = CHAR_W'(pc);
        c.col   = 9'(col);
        c.row   = 9'(row);
        return c;
    endfunction

    function automatic paint_cmd_t mk_draw(int l, int t, int w, int h, int ft, int pc);
        return mk_cmd(OP_DRAW, l, t, w, h, ft, pc, 0, 0);
    endfunction

    function automatic paint_cmd_t mk_read(int col, int row);
        return mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, col, row);
    endfunction

    function automatic stim_row_t typed_row(paint_cmd_t c, logic [1:0] st,
                                            logic [CHAR_W-1:0] px);
        stim_row_t r;
        r = '{default: '0};
        r.cmd         = c;
        r.typed       = 1'b1;
        r.want.status = st;
        r.want.pixel  = px;
        return r;
    endfunction

    function automatic stim_row_t checked_row(paint_cmd_t c);
        stim_row_t r;
        r = '{default: '0};
        r.cmd = c;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(logic [1:0] idx, logic [31:0] val);
        stim_row_t r;
        r = '{default: '0};
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // Random command word. Every field starts fully random so that all bits
    // toggle; most draws are then reshaped into rectangles that land on or near
    // the in-use canvas, and most reads into pixels inside it.
    function automatic paint_cmd_t random_cmd(int cols, int rows);
        paint_cmd_t c;
        int         sel;
        c = mk_cmd(OP_NOP, int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                   int'($urandom), int'($urandom), int'($urandom), int'($urandom));
        sel = int'($urandom_range(99));
        if (sel < 48)
        begin
            c.op = OP_DRAW;
            if ($urandom_range(9) < 8)
            begin
                c.left = FIELD_W'(int'($urandom_range(0, (cols + 4) * UNIT)) - 2 * UNIT);
                c.top  = FIELD_W'(int'($urandom_range(0, (rows + 4) * UNIT)) - 2 * UNIT);
                if ($urandom_range(3) == 0)
                begin
                    // Thin shapes, down to a single point or line.
                    c.wid = FIELD_W'($urandom_range(0, 3 * UNIT));
                    c.hgt = FIELD_W'($urandom_range(0, 3 * UNIT));
                end
                else
                begin
                    c.wid = FIELD_W'($urandom_range(0, (cols + 2) * UNIT));
                    c.hgt = FIELD_W'($urandom_range(0, (rows + 2) * UNIT));
                end
                c.ftype = $urandom_range(1) ? TYPE_FULL : TYPE_OUTLINE;
            end
            else if ($urandom_range(1))
            begin
                // Noise coordinates with a legal type, so that wild values are
                // accepted as well as rejected.
                c.ftype = $urandom_range(1) ? TYPE_FULL : TYPE_OUTLINE;
            end
        end
        else if (sel < 94)
        begin
            c.op = OP_READ;
            if ($urandom_range(9) < 7)
            begin
                c.col = 9'($urandom_range(0, cols - 1));
                c.row = 9'($urandom_range(0, rows - 1));
            end
        end
        return c;
    endfunction

    task automatic report_mismatch(input string what, input canvas_word_t want,
                                   input canvas_word_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] %s: expected status %0d pixel 0x%02h, got status %0d pixel 0x%02h",
                     $realtime, what, want.status, want.pixel, got.status, got.pixel);
    endtask

    // Results cannot be held off, so every cycle with done high is one word.
    // Sampling at the edge sees the values that the block drove in the cycle
    // before it.
    always @(posedge clk)
    begin : result_check
        canvas_word_t got;
        canvas_word_t want;
        if (rst_n && done)
        begin
            got.status = status;
            got.pixel  = pixel_value;
            if (predicted_words.size() == 0)
            begin
                want = '{default: '0};
                report_mismatch("result word with nothing outstanding", want, got);
            end
            else
            begin
                want = predicted_words.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status mismatch", want, got);
                if (got.pixel !== want.pixel)
                    report_mismatch("pixel_value mismatch", want, got);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("rectangle_raster_painter_tb: FAIL");
            $finish;
        end
    end

    // Presents a word and holds it until the block takes it: the word is
    // accepted at the first edge that sees start high and busy low. The caller
    // either presents the next word at once, keeping start high, or drops start.
    task automatic send_word(input paint_cmd_t c, input bit typed, input canvas_word_t want);
        canvas_word_t predicted;
        start       <= 1'b1;
        opcode      <= c.op;
        rect_left   <= c.left;
        rect_top    <= c.top;
        rect_width  <= c.wid;
        rect_height <= c.hgt;
        fill_type   <= c.ftype;
        paint_char  <= c.paint;
        pixel_col   <= c.col;
        pixel_row   <= c.row;
        do
            @(posedge clk);
        while (busy);
        // The predictor always runs so the shadow canvas tracks the block; a
        // typed-in row checks against its own value instead.
        canvas_predict(c, predicted);
        predicted_words.push_back(typed ? want : predicted);
    endtask

    // Stops sending and waits until every outstanding word has come back, then
    // waits on so that the block is surely idle.
    task automatic wait_drained();
        start <= 1'b0;
        while (predicted_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write: a setup phase, then an access phase that ends at the edge that
    // sees pready high. An idle phase follows so the next write starts clean.
    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CANVAS_WIDTH:  shadow_width  = val[SIZE_W-1:0];
            REG_CANVAS_HEIGHT: shadow_height = val[SIZE_W-1:0];
            REG_BACKGROUND:    shadow_bg     = val[CHAR_W-1:0];
            default:
            begin
            end
        endcase
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        paint_cmd_t   c;
        canvas_word_t none;
        int           sent;
        int           idle_pct;
        none = '{default: '0};
        sent = 0;

        // Directed table. Canvas contents are undefined after reset, so no
        // in-canvas read comes before the first clear.
        directed_rows.push_back(typed_row(mk_cmd(OP_NOP, 0, 0, 0, 0, 0, 0, 0, 0),
                                          ST_OK, 8'h00));
        // Rejections: negative width, most negative height, and bad type bytes.
        directed_rows.push_back(typed_row(mk_draw(0, 0, -UNIT, UNIT, TYPE_FULL, 8'h41),
                                          ST_REJECT, 8'h00));
        directed_rows.push_back(typed_row(mk_draw(0, 0, UNIT, FIELD_MIN, TYPE_OUTLINE, 8'h41),
                                          ST_REJECT, 8'h00));
        directed_rows.push_back(typed_row(mk_draw(0, 0, UNIT, UNIT, 8'h00, 8'h41),
                                          ST_REJECT, 8'h00));
        directed_rows.push_back(typed_row(mk_draw(0, 0, UNIT, UNIT, 8'hFF, 8'h41),
                                          ST_REJECT, 8'h00));
        directed_rows.push_back(typed_row(mk_draw(0, 0, UNIT, UNIT, 8'h53, 8'h41),
                                          ST_REJECT, 8'h00));
        // Clear with the reset background, then the far corners read it back.
        directed_rows.push_back(typed_row(mk_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0),
                                          ST_OK, 8'h00));
        directed_rows.push_back(typed_row(mk_read(0, 0), ST_OK, RST_BACKGROUND));
        directed_rows.push_back(typed_row(mk_read(511, 511), ST_OK, RST_BACKGROUND));
        // Outline hugging the full 512 by 512 canvas.
        directed_rows.push_back(checked_row(mk_draw(0, 0, 511 * UNIT, 511 * UNIT,
                                                    TYPE_OUTLINE, 8'h23)));
        directed_rows.push_back(checked_row(mk_read(511, 511)));
        directed_rows.push_back(checked_row(mk_read(255, 300)));
        // Shrink the canvas to keep the remaining sweeps short.
        directed_rows.push_back(cfg_row(REG_CANVAS_WIDTH, 32'd16));
        directed_rows.push_back(cfg_row(REG_CANVAS_HEIGHT, 32'd12));
        directed_rows.push_back(typed_row(mk_read(16, 0), ST_OUTSIDE, 8'h00));
        directed_rows.push_back(typed_row(mk_read(511, 511), ST_OUTSIDE, 8'h00));
        // Coordinate extremes, a fractional rectangle, a zero-size point and a
        // rectangle hanging off the top left corner.
        directed_rows.push_back(checked_row(mk_draw(FIELD_MIN, FIELD_MIN, FIELD_MAX, FIELD_MAX,
                                                    TYPE_FULL, 8'h2A)));
        directed_rows.push_back(checked_row(mk_draw(FIELD_MAX, FIELD_MAX, 0, 0,
                                                    TYPE_OUTLINE, 8'h2B)));
        directed_rows.push_back(checked_row(mk_draw(640, 320, 5 * UNIT, 1216,
                                                    TYPE_FULL, 8'h2E)));
        directed_rows.push_back(checked_row(mk_draw(3 * UNIT, 3 * UNIT, 0, 0,
                                                    TYPE_OUTLINE, 8'h6F)));
        directed_rows.push_back(checked_row(mk_draw(-896, -512, 10 * UNIT, 20 * UNIT,
                                                    TYPE_OUTLINE, 8'h00)));
        directed_rows.push_back(checked_row(mk_read(3, 3)));
        directed_rows.push_back(typed_row(mk_cmd(OP_NOP, FIELD_MAX, FIELD_MAX, FIELD_MAX,
                                                 FIELD_MAX, 255, 255, 511, 511),
                                          ST_OK, 8'h00));
        // Empty canvas along each axis: draws touch nothing and reads are outside.
        directed_rows.push_back(cfg_row(REG_CANVAS_WIDTH, 32'd0));
        directed_rows.push_back(typed_row(mk_read(0, 0), ST_OUTSIDE, 8'h00));
        directed_rows.push_back(typed_row(mk_draw(0, 0, UNIT, UNIT, TYPE_FULL, 8'h58),
                                          ST_OK, 8'h00));
        directed_rows.push_back(cfg_row(REG_CANVAS_WIDTH, 32'd5));
        directed_rows.push_back(cfg_row(REG_CANVAS_HEIGHT, 32'd0));
        directed_rows.push_back(typed_row(mk_draw(0, 0, UNIT, UNIT, TYPE_OUTLINE, 8'h58),
                                          ST_OK, 8'h00));
        directed_rows.push_back(typed_row(mk_read(0, 0), ST_OUTSIDE, 8'h00));
        // New background, a write past the register map, then a second clear.
        directed_rows.push_back(cfg_row(REG_BACKGROUND, 32'h0000_00FF));
        directed_rows.push_back(cfg_row(REG_UNMAPPED, 32'hFFFF_FFFF));
        directed_rows.push_back(cfg_row(REG_CANVAS_WIDTH, 32'd8));
        directed_rows.push_back(cfg_row(REG_CANVAS_HEIGHT, 32'd8));
        directed_rows.push_back(typed_row(mk_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0),
                                          ST_OK, 8'h00));
        directed_rows.push_back(typed_row(mk_read(7, 7), ST_OK, 8'hFF));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
            begin
                wait_drained();
                cfg_write(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            end
            else
                send_word(directed_rows[i].cmd, directed_rows[i].typed,
                          directed_rows[i].want);
        end

        // Random part. Clears are left out here: each one sweeps the whole store
        // and the directed table already runs two. Phases alternate between a
        // small canvas and single-row and single-column canvases whose size
        // registers sit at the top of their range.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_drained();
            case (ph)
                1:
                begin
                    cfg_write(REG_CANVAS_WIDTH, 32'd1023);
                    cfg_write(REG_CANVAS_HEIGHT, 32'd1);
                end
                2:
                begin
                    cfg_write(REG_CANVAS_WIDTH, 32'd1);
                    cfg_write(REG_CANVAS_HEIGHT, 32'd1023);
                end
                default:
                begin
                    cfg_write(REG_CANVAS_WIDTH, 32'($urandom_range(1, 24)));
                    cfg_write(REG_CANVAS_HEIGHT, 32'($urandom_range(1, 20)));
                end
            endcase
            for (int k = 0; k < WORDS_PER_PHASE; k++)
            begin
                // The sender idles rarely at first, then often, then never.
                idle_pct = (sent < RANDOM_WORDS / 3) ? 9 :
                           ((sent < 2 * RANDOM_WORDS / 3) ? 46 : 0);
                if ($urandom_range(99) < 3)
                    wait_drained();
                else if ($urandom_range(99) < idle_pct)
                begin
                    start <= 1'b0;
                    do
                        @(posedge clk);
                    while ($urandom_range(99) < idle_pct);
                end
                c = random_cmd(used_cols(), used_rows());
                send_word(c, 1'b0, none);
                sent++;
            end
        end

        // Drain, then give the block room to show any stray result word.
        wait_drained();
        repeat (50) @(posedge clk);
        if (mismatch_count == 0 && predicted_words.size() == 0)
            $display("rectangle_raster_painter_tb: PASS");
        else
            $display("rectangle_raster_painter_tb: FAIL");
        $finish;
    end

endmodule
